// ===== rtl/core/sti_pkg.sv =====
package sti_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int DATA_WIDTH  = 32;

  localparam int FieldW    = 32;
  localparam int StoreW    = (DATA_WIDTH < FieldW) ? DATA_WIDTH : FieldW;
  localparam int AddrW     = $clog2(TABLE_DEPTH);
  localparam int CntW      = $clog2(TABLE_DEPTH + 1);
  localparam int LenW      = 11;
  localparam int IdxW      = 10;
  localparam int WgtW      = 16;
  localparam int LEN_RESET = 1024;

  // serial divider: one quotient bit per cycle
  localparam int WGT_STEPS = WgtW;
  localparam int MAG_STEPS = FieldW;
  localparam int StepW     = $clog2(MAG_STEPS);

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } sti_func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_BELOW     = 2'd2,
    ST_ABOVE     = 2'd3
  } sti_status_e;

  typedef struct packed {
    sti_func_e                func;
    logic [IdxW-1:0]          entry_index;
    logic signed [FieldW-1:0] entry_key;
    logic signed [FieldW-1:0] entry_value;
    logic signed [FieldW-1:0] query_key;
  } sti_req_t;

  typedef struct packed {
    logic signed [FieldW-1:0] interp_value;
    sti_status_e              status;
    logic [IdxW-1:0]          right_index;
    logic [WgtW-1:0]          weight;
  } sti_rsp_t;

  // one extra bit for key and value differences
  typedef logic signed [FieldW:0] sti_dif_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_FETCH,
    S_DIFF,
    S_PREP,
    S_MUL,
    S_WDIV,
    S_MINIT,
    S_MDIV,
    S_FIN
  } sti_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRCH_RD,
    OP_CHECK,
    OP_SRCH_CMP,
    OP_RD_RIGHT,
    OP_DIFF,
    OP_PREP,
    OP_MUL,
    OP_DIV_STEP,
    OP_MINIT,
    OP_FINISH
  } sti_op_e;

  typedef struct packed {
    logic is_write;
    logic ready;
    logic count_zero;
    logic range_err;
    logic dk_pos;
  } sti_stat_t;

endpackage

// ===== rtl/core/sti_dpath.sv =====
module sti_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sti_pkg::sti_op_e            op_i,
  input  sti_pkg::sti_req_t           req_i,
  input  logic                        cfg_we_i,
  input  logic [sti_pkg::LenW-1:0]    cfg_wdata_i,
  output sti_pkg::sti_stat_t          stat_o,
  output sti_pkg::sti_rsp_t           rsp_o
);

  logic [sti_pkg::LenW-1:0] len_q;
  logic                     ready_q;

  logic [2*sti_pkg::StoreW-1:0] tbl_mem [sti_pkg::TABLE_DEPTH];
  logic [2*sti_pkg::StoreW-1:0] rd_q;
  logic                         mem_we;
  logic                         mem_re;
  logic [sti_pkg::AddrW-1:0]    mem_addr;

  logic [sti_pkg::CntW-1:0] eff_len;
  logic [sti_pkg::CntW-1:0] first_q;
  logic [sti_pkg::CntW-1:0] count_q;
  logic [sti_pkg::CntW-1:0] half;
  logic [sti_pkg::CntW-1:0] mid;

  logic signed [sti_pkg::FieldW-1:0] q_q;
  logic signed [sti_pkg::FieldW-1:0] rd_key;
  logic signed [sti_pkg::FieldW-1:0] rd_val;
  logic signed [sti_pkg::FieldW-1:0] kl_q;
  logic signed [sti_pkg::FieldW-1:0] vl_q;

  sti_pkg::sti_dif_t dk_q;
  sti_pkg::sti_dif_t dq_q;
  sti_pkg::sti_dif_t dv_q;
  sti_pkg::sti_dif_t dv_abs;

  logic [sti_pkg::FieldW-1:0]   dk_u_q;
  logic [sti_pkg::FieldW-1:0]   dqc_q;
  logic [sti_pkg::FieldW-1:0]   dqc_d;
  logic [sti_pkg::FieldW-1:0]   dvmag_q;
  logic                         dk_pos_q;
  logic                         dv_neg_q;
  logic                         sat_q;
  logic [2*sti_pkg::FieldW-1:0] prod;
  logic [2*sti_pkg::FieldW-1:0] prod_q;

  logic [sti_pkg::FieldW-1:0] rem_q;
  logic [sti_pkg::FieldW-1:0] rem_d;
  logic [sti_pkg::FieldW-1:0] lo_q;
  logic [sti_pkg::FieldW-1:0] quo_q;
  logic [sti_pkg::FieldW:0]   trial;
  logic [sti_pkg::FieldW:0]   trial_sub;
  logic                       qbit;
  logic [sti_pkg::WgtW-1:0]   wgt_q;

  sti_pkg::sti_rsp_t rsp_q;
  sti_pkg::sti_rsp_t rsp_d;
  logic              rsp_we;

  logic is_write;
  logic range_err;
  logic ge_key;

  assign is_write = (req_i.func == sti_pkg::FUNC_WRITE);

  always_comb begin
    if (len_q < sti_pkg::LenW'(2)) begin
      eff_len = sti_pkg::CntW'(2);
    end else if (32'(len_q) > 32'(sti_pkg::TABLE_DEPTH)) begin
      eff_len = sti_pkg::CntW'(sti_pkg::TABLE_DEPTH);
    end else begin
      eff_len = sti_pkg::CntW'(len_q);
    end
  end

  // upper bound probe point
  assign half = count_q >> 1;
  assign mid  = first_q + half;

  assign rd_key = sti_pkg::FieldW'(signed'(rd_q[2*sti_pkg::StoreW-1 -: sti_pkg::StoreW]));
  assign rd_val = sti_pkg::FieldW'(signed'(rd_q[sti_pkg::StoreW-1:0]));
  assign ge_key = (q_q >= rd_key);

  assign range_err = (first_q == '0) || (first_q >= eff_len);

  assign mem_we = (op_i == sti_pkg::OP_LOAD) && is_write &&
                  (32'(req_i.entry_index) < 32'(sti_pkg::TABLE_DEPTH));
  assign mem_re = (op_i == sti_pkg::OP_SRCH_RD) || (op_i == sti_pkg::OP_CHECK) ||
                  (op_i == sti_pkg::OP_RD_RIGHT);

  always_comb begin
    case (op_i)
      sti_pkg::OP_LOAD:    mem_addr = sti_pkg::AddrW'(req_i.entry_index);
      sti_pkg::OP_SRCH_RD: mem_addr = sti_pkg::AddrW'(mid);
      sti_pkg::OP_CHECK:   mem_addr = sti_pkg::AddrW'(first_q - sti_pkg::CntW'(1));
      default:             mem_addr = sti_pkg::AddrW'(first_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_addr] <= {req_i.entry_key[sti_pkg::StoreW-1:0],
                            req_i.entry_value[sti_pkg::StoreW-1:0]};
    end
    if (mem_re) begin
      rd_q <= tbl_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= sti_pkg::LenW'(sti_pkg::LEN_RESET);
      ready_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (mem_we && (32'(req_i.entry_index) == 32'(eff_len) - 32'd1)) begin
        ready_q <= 1'b1;
      end
    end
  end

  // clamp dq to [0, dk] and take |dv|
  assign dv_abs = -dv_q;

  always_comb begin
    if (dq_q[sti_pkg::FieldW]) begin
      dqc_d = '0;
    end else if (dq_q > dk_q) begin
      dqc_d = dk_q[sti_pkg::FieldW-1:0];
    end else begin
      dqc_d = dq_q[sti_pkg::FieldW-1:0];
    end
  end

  assign prod = {{sti_pkg::FieldW{1'b0}}, dvmag_q} * {{sti_pkg::FieldW{1'b0}}, dqc_q};

  // restoring divide step; the remainder stays below dk except when dq equals dk
  assign trial     = {rem_q, lo_q[sti_pkg::FieldW-1]};
  assign trial_sub = trial - {1'b0, dk_u_q};
  assign qbit      = (trial >= {1'b0, dk_u_q});
  assign rem_d     = qbit ? trial_sub[sti_pkg::FieldW-1:0] : trial[sti_pkg::FieldW-1:0];

  always_ff @(posedge clk_i) begin
    case (op_i)
      sti_pkg::OP_LOAD: begin
        q_q     <= req_i.query_key;
        first_q <= '0;
        count_q <= eff_len;
      end
      sti_pkg::OP_SRCH_CMP: begin
        if (ge_key) begin
          first_q <= mid + sti_pkg::CntW'(1);
          count_q <= count_q - half - sti_pkg::CntW'(1);
        end else begin
          count_q <= half;
        end
      end
      sti_pkg::OP_RD_RIGHT: begin
        kl_q <= rd_key;
        vl_q <= rd_val;
      end
      sti_pkg::OP_DIFF: begin
        dk_q <= sti_pkg::sti_dif_t'(rd_key) - sti_pkg::sti_dif_t'(kl_q);
        dq_q <= sti_pkg::sti_dif_t'(q_q) - sti_pkg::sti_dif_t'(kl_q);
        dv_q <= sti_pkg::sti_dif_t'(rd_val) - sti_pkg::sti_dif_t'(vl_q);
      end
      sti_pkg::OP_PREP: begin
        dk_u_q   <= dk_q[sti_pkg::FieldW-1:0];
        dk_pos_q <= !dk_q[sti_pkg::FieldW] && (dk_q != '0);
        dqc_q    <= dqc_d;
        dvmag_q  <= dv_q[sti_pkg::FieldW] ? dv_abs[sti_pkg::FieldW-1:0]
                                          : dv_q[sti_pkg::FieldW-1:0];
        dv_neg_q <= dv_q[sti_pkg::FieldW];
      end
      sti_pkg::OP_MUL: begin
        prod_q <= prod;
        rem_q  <= dqc_q;
        lo_q   <= '0;
        quo_q  <= '0;
        // dq equal to dk would give a full weight of one
        sat_q  <= (dqc_q == dk_u_q);
      end
      sti_pkg::OP_DIV_STEP: begin
        rem_q <= rem_d;
        lo_q  <= {lo_q[sti_pkg::FieldW-2:0], 1'b0};
        quo_q <= {quo_q[sti_pkg::FieldW-2:0], qbit};
      end
      sti_pkg::OP_MINIT: begin
        wgt_q <= sat_q ? '1 : quo_q[sti_pkg::WgtW-1:0];
        rem_q <= prod_q[2*sti_pkg::FieldW-1:sti_pkg::FieldW];
        lo_q  <= prod_q[sti_pkg::FieldW-1:0];
        quo_q <= '0;
      end
      default: ;
    endcase
    if (rsp_we) begin
      rsp_q <= rsp_d;
    end
  end

  always_comb begin
    rsp_d  = '0;
    rsp_we = 1'b0;
    case (op_i)
      sti_pkg::OP_LOAD: begin
        rsp_we       = is_write || !ready_q;
        rsp_d.status = is_write ? sti_pkg::ST_OK : sti_pkg::ST_NOT_READY;
      end
      sti_pkg::OP_CHECK: begin
        rsp_we       = range_err;
        rsp_d.status = (first_q == '0) ? sti_pkg::ST_BELOW : sti_pkg::ST_ABOVE;
      end
      sti_pkg::OP_FINISH: begin
        rsp_we            = 1'b1;
        rsp_d.status      = sti_pkg::ST_OK;
        rsp_d.right_index = sti_pkg::IdxW'(first_q);
        if (dk_pos_q) begin
          rsp_d.interp_value = dv_neg_q ? vl_q - quo_q : vl_q + quo_q;
          rsp_d.weight       = wgt_q;
        end else begin
          rsp_d.interp_value = vl_q;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.is_write   = is_write;
  assign stat_o.ready      = ready_q;
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.range_err  = range_err;
  assign stat_o.dk_pos     = dk_pos_q;

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/core/sti_ctrl.sv =====
module sti_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  sti_pkg::sti_stat_t stat_i,
  output sti_pkg::sti_op_e   op_o,
  output logic               busy_o,
  output logic               done_o
);

  sti_pkg::sti_state_e       state_q;
  sti_pkg::sti_state_e       state_d;
  logic [sti_pkg::StepW-1:0] cnt_q;
  logic [sti_pkg::StepW-1:0] cnt_d;
  logic                      done_q;
  logic                      done_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      sti_pkg::S_IDLE: begin
        if (start_i && !stat_i.is_write && stat_i.ready) begin
          state_d = sti_pkg::S_SRCH;
        end
      end
      sti_pkg::S_SRCH: begin
        if (stat_i.count_zero) begin
          state_d = stat_i.range_err ? sti_pkg::S_IDLE : sti_pkg::S_FETCH;
        end else begin
          state_d = sti_pkg::S_CMP;
        end
      end
      sti_pkg::S_CMP:   state_d = sti_pkg::S_SRCH;
      sti_pkg::S_FETCH: state_d = sti_pkg::S_DIFF;
      sti_pkg::S_DIFF:  state_d = sti_pkg::S_PREP;
      sti_pkg::S_PREP:  state_d = sti_pkg::S_MUL;
      sti_pkg::S_MUL: begin
        if (stat_i.dk_pos) begin
          state_d = sti_pkg::S_WDIV;
          cnt_d   = sti_pkg::StepW'(sti_pkg::WGT_STEPS - 1);
        end else begin
          state_d = sti_pkg::S_FIN;
        end
      end
      sti_pkg::S_WDIV: begin
        if (cnt_q == '0) begin
          state_d = sti_pkg::S_MINIT;
        end else begin
          cnt_d = cnt_q - sti_pkg::StepW'(1);
        end
      end
      sti_pkg::S_MINIT: begin
        state_d = sti_pkg::S_MDIV;
        cnt_d   = sti_pkg::StepW'(sti_pkg::MAG_STEPS - 1);
      end
      sti_pkg::S_MDIV: begin
        if (cnt_q == '0) begin
          state_d = sti_pkg::S_FIN;
        end else begin
          cnt_d = cnt_q - sti_pkg::StepW'(1);
        end
      end
      sti_pkg::S_FIN: state_d = sti_pkg::S_IDLE;
      default:        state_d = sti_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_o   = sti_pkg::OP_NONE;
    done_d = 1'b0;
    unique case (state_q)
      sti_pkg::S_IDLE: begin
        if (start_i) begin
          op_o   = sti_pkg::OP_LOAD;
          done_d = stat_i.is_write || !stat_i.ready;
        end
      end
      sti_pkg::S_SRCH: begin
        if (stat_i.count_zero) begin
          op_o   = sti_pkg::OP_CHECK;
          done_d = stat_i.range_err;
        end else begin
          op_o = sti_pkg::OP_SRCH_RD;
        end
      end
      sti_pkg::S_CMP:   op_o = sti_pkg::OP_SRCH_CMP;
      sti_pkg::S_FETCH: op_o = sti_pkg::OP_RD_RIGHT;
      sti_pkg::S_DIFF:  op_o = sti_pkg::OP_DIFF;
      sti_pkg::S_PREP:  op_o = sti_pkg::OP_PREP;
      sti_pkg::S_MUL:   op_o = sti_pkg::OP_MUL;
      sti_pkg::S_WDIV:  op_o = sti_pkg::OP_DIV_STEP;
      sti_pkg::S_MINIT: op_o = sti_pkg::OP_MINIT;
      sti_pkg::S_MDIV:  op_o = sti_pkg::OP_DIV_STEP;
      sti_pkg::S_FIN: begin
        op_o   = sti_pkg::OP_FINISH;
        done_d = 1'b1;
      end
      default: op_o = sti_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sti_pkg::S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != sti_pkg::S_IDLE);
  assign done_o = done_q;

endmodule

// ===== rtl/core/sorted_table_linear_interpolator.sv =====
// Sorted-table linear interpolator. A beat with func = write stores one key/value entry and
// returns a write-done result on done_o in the next cycle; a query beat before the entry at
// table_length-1 (table_length clamped to 2..1024) has been written returns not-ready, also in
// the next cycle. A query on a ready table runs a binary upper-bound search over the table
// memory, each probe reading an entry and then comparing it (at most floor(log2 n)+1 probes,
// 11 for 1024 entries), then a range check; out-of-range queries end there. An in-range query
// then fetches the neighbor entry, takes the differences and forms the product, divides for the
// weight and then for the value in a one-bit-per-cycle divider, and forms the result; when the
// two keys do not rise, the divides are skipped. The table memory is single-port and the
// divider serial. Each result shows for exactly one cycle with done_o high and must be taken
// then; the next beat is accepted in that same cycle. The user must write table_length only
// while busy is low and no result is pending; the block itself does not enforce this.
module sorted_table_linear_interpolator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  sti_pkg::sti_req_t        req_i,
  output logic                     done_o,
  output sti_pkg::sti_rsp_t        rsp_o,
  input  logic                     cfg_we_i,
  input  logic [sti_pkg::LenW-1:0] cfg_wdata_i
);

  sti_pkg::sti_op_e   op;
  sti_pkg::sti_stat_t stat;

  sti_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .op_o    (op),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  sti_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_o      (stat),
    .rsp_o       (rsp_o)
  );

`ifndef ASSERT_OFF
  // a result beat always comes with the block free for the next item
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  a_write_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.func == sti_pkg::FUNC_WRITE))
      |=> (done_o && (rsp_o.status == sti_pkg::ST_OK)))
    else $error("write beat did not finish in the next cycle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status != sti_pkg::ST_OK))
      |-> ((rsp_o.interp_value == '0) && (rsp_o.right_index == '0) && (rsp_o.weight == '0)))
    else $error("error result with nonzero fields");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted beat");
`endif

endmodule
